// ===== src/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg
// Shared constants and types for the keyboard matrix scanner: matrix size,
// command and pending-flag codes, and the item and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

  localparam int ROWS       = 9;
  localparam int COLS       = 6;
  localparam int LINE_COUNT = 9;

  localparam int CMD_W  = 3;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 3;
  localparam int SCAN_W = 8;
  localparam int NIB_W  = 4;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_KEY_PRESS   = 3'd0,
    CMD_KEY_RELEASE = 3'd1,
    CMD_ON_PRESS    = 3'd2,
    CMD_ON_RELEASE  = 3'd3,
    CMD_LINES       = 3'd4
  } kms_cmd_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_SET   = 2'd1,
    PEND_CLEAR = 2'd2
  } kms_pend_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [LINE_COUNT-1:0] lines;
    logic                  cpu_shutdown;
    logic                  key_scan_enabled;
    logic                  irq_enabled;
  } kms_item_t;

  typedef struct packed {
    logic [NIB_W-1:0] in_low;
    logic [NIB_W-1:0] in_high;
    logic             on_line;
    logic             wake;
    logic             irq_request;
    kms_pend_t        pending_action;
  } kms_result_t;

endpackage

`default_nettype wire

// ===== src/kms_in_stage.sv =====
// ----------------------------------------------------------------------------
// kms_in_stage
// Input register: captures one transaction and holds it until the core
// consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_in_stage
  import kms_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [IN_USER_W-1:0] in_tuser,
  input  wire logic                 advance,
  output logic                      item_valid,
  output kms_item_t                 item
);

  logic      valid_r;
  logic      valid_nxt;
  kms_item_t item_r;
  kms_item_t item_nxt;
  logic      take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_comb begin
    item_nxt                  = item_r;
    if (take) begin
      item_nxt.cmd              = in_tuser[CMD_W-1:0];
      item_nxt.row              = in_tdata[3:0];
      item_nxt.col              = in_tdata[6:4];
      item_nxt.lines            = in_tdata[15:7];
      item_nxt.cpu_shutdown     = in_tdata[16];
      item_nxt.key_scan_enabled = in_tdata[17];
      item_nxt.irq_enabled      = in_tdata[18];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== src/kms_core.sv =====
// ----------------------------------------------------------------------------
// kms_core
// Key matrix state, rescan OR tree and wake/interrupt/pending flag logic.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_core
  import kms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire kms_item_t  item,
  output kms_result_t     result
);

  logic [COLS-1:0]              matrix_r   [ROWS];
  logic [COLS-1:0]              matrix_nxt [ROWS];
  logic                         on_r;
  logic                         on_nxt;
  logic [SCAN_W-1:0]            scan_r;
  logic [SCAN_W-1:0]            scan_nxt;
  logic [COLS-1:0]              col_bits;
  logic [ROWS+LINE_COUNT-1:0]   lines_ext;
  logic [COLS-1:0]              acc;
  logic [SCAN_W-1:0]            scan_new;
  logic                         is_key;
  logic                         is_press;
  logic                         was_none;
  logic                         any_now;

  assign is_press  = (item.cmd == CMD_KEY_PRESS);
  assign is_key    = is_press || (item.cmd == CMD_KEY_RELEASE);
  assign lines_ext = {{ROWS{1'b0}}, item.lines};
  assign was_none  = (scan_r == '0) && !on_r;

  // Column decode; an out-of-range column gives no bit, so the write drops.
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_bits[c] = (item.col == COL_W'(c));
    end
  end

  // Apply the key write, then OR every row whose output line is high.
  always_comb begin
    acc = '0;
    for (int r = 0; r < ROWS; r++) begin
      matrix_nxt[r] = matrix_r[r];
      if (is_key && (item.row == ROW_W'(r))) begin
        if (is_press) begin
          matrix_nxt[r] = matrix_r[r] | col_bits;
        end else begin
          matrix_nxt[r] = matrix_r[r] & ~col_bits;
        end
      end
      if (lines_ext[r]) begin
        acc = acc | matrix_nxt[r];
      end
    end
    scan_new = SCAN_W'(acc);
  end

  assign any_now = (scan_new != '0) || on_r;

  always_comb begin
    on_nxt                = on_r;
    scan_nxt              = scan_r;
    result.wake           = 1'b0;
    result.irq_request    = 1'b0;
    result.pending_action = PEND_NONE;
    case (item.cmd)
      CMD_KEY_PRESS: begin
        scan_nxt = scan_new;
        if (was_none && any_now) begin
          result.wake = item.cpu_shutdown;
          if (item.key_scan_enabled) begin
            if (item.irq_enabled) begin
              result.irq_request    = 1'b1;
              result.pending_action = PEND_CLEAR;
            end else begin
              result.pending_action = PEND_SET;
            end
          end
        end else if (!any_now) begin
          result.pending_action = PEND_CLEAR;
        end
      end
      CMD_KEY_RELEASE: begin
        scan_nxt = scan_new;
        if (!any_now) begin
          result.pending_action = PEND_CLEAR;
        end
      end
      CMD_ON_PRESS: begin
        on_nxt = 1'b1;
        if (!on_r) begin
          result.wake        = item.cpu_shutdown;
          result.irq_request = item.irq_enabled;
        end
      end
      CMD_ON_RELEASE: begin
        on_nxt = 1'b0;
      end
      CMD_LINES: begin
        scan_nxt = scan_new;
      end
      default: begin
      end
    endcase
    result.in_low  = scan_nxt[NIB_W-1:0];
    result.in_high = scan_nxt[SCAN_W-1:NIB_W];
    result.on_line = on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r   <= 1'b0;
      scan_r <= '0;
      for (int r = 0; r < ROWS; r++) begin
        matrix_r[r] <= '0;
      end
    end else if (fire) begin
      on_r   <= on_nxt;
      scan_r <= scan_nxt;
      if (is_key) begin
        for (int r = 0; r < ROWS; r++) begin
          matrix_r[r] <= matrix_nxt[r];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/kms_out_stage.sv =====
// ----------------------------------------------------------------------------
// kms_out_stage
// Result register: holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_out_stage
  import kms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire kms_result_t           result,
  output logic                       advance,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic        valid_r;
  logic        valid_nxt;
  kms_result_t res_r;
  kms_result_t res_nxt;

  assign advance = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = result;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, 2'(res_r.pending_action), res_r.irq_request, res_r.wake,
                       res_r.on_line, res_r.in_high, res_r.in_low};

endmodule

`default_nettype wire

// ===== src/keyboard_matrix_scanner.sv =====
// ----------------------------------------------------------------------------
// keyboard_matrix_scanner
// Emulated calculator keyboard matrix with rescan and key-event flags.
// ----------------------------------------------------------------------------
// Input channel (in_*): one transaction per command; in_tuser carries the
// command code, in_tdata the key position, output lines and CPU status.
// Result channel (out_*): exactly one transaction per command with the
// scanned input nibbles, the ON line and the wake/interrupt/pending flags.
// The input register loads at the accepting edge; the matrix update and OR
// tree then feed the result register once it can advance (result register
// empty or out_tready high).
// Throughput is one command per cycle while out_tready stays high; the row
// registers and the scan word update once per accepted command.
// Reset (rst_n low, synchronous) releases all keys and the ON key and
// clears the scanned input; both channels come up empty.
// When out_tready is low the result holds; the input register still takes
// one more transaction, then in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_matrix_scanner
  import kms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [3:0] row, [6:4] col, [15:7] out_lines, [16] cpu_shutdown,
  // [17] key_scan_enabled, [18] irq_enabled, [23:19] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] command, [7:3] zero
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [3:0] in_low, [7:4] in_high, [8] on_line, [9] wake, [10] irq_request,
  // [12:11] pending_action, [15:13] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  logic        advance;
  logic        item_valid;
  logic        fire;
  kms_item_t   item;
  kms_result_t result;

  assign fire = item_valid && advance;

  kms_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  kms_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  kms_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // An empty result register must never block the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with empty result register");

  a_pend_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:11] != 2'd3))
    else $error("undefined pending_action code");

  // An interrupt is never raised together with setting pending.
  a_irq_vs_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[10]) |-> (out_tdata[12:11] != 2'(PEND_SET)))
    else $error("irq_request with pending set");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("accepted command produced no result");
`endif

endmodule

`default_nettype wire
